[src/jbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG bit packer package
// Shared payload types, command codes and constants of the bit packer.
// ----------------------------------------------------------------------------
package jbp_pkg;

  localparam int MAX_CODE_LEN_DEFAULT = 16;
  localparam int CMD_FIFO_DEPTH       = 2;
  localparam int OUT_FIFO_DEPTH       = 4;
  localparam int BYTE_BITS            = 8;

  localparam logic       CMD_WRITE     = 1'b0;
  localparam logic       CMD_ALIGN     = 1'b1;
  localparam logic [7:0] STUFF_TRIGGER = 8'hFF;
  localparam logic [7:0] STUFF_BYTE    = 8'h00;

  typedef struct packed {
    logic        cmd;
    logic [15:0] code_value;
    logic [4:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

endpackage

[src/jbp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG bit packer queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module jbp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/jbp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG bit packer front end
// Accepts transactions, clamps the code length and left-aligns the code bits.
// ----------------------------------------------------------------------------
module jbp_front #(
  parameter int MaxCodeLen = 16,
  parameter int CmdW       = 1 + $clog2(MaxCodeLen + 1) + MaxCodeLen
) (
  input  logic              push_i,
  input  jbp_pkg::in_item_t in_data_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output logic [CmdW-1:0]   cmd_data_o
);
  import jbp_pkg::*;

  localparam int LenW = $clog2(MaxCodeLen + 1);

  typedef struct packed {
    logic                  align;
    logic [LenW-1:0]       len;
    logic [MaxCodeLen-1:0] bits;
  } cmd_t;

  cmd_t        cmd;
  logic [31:0] shifted;

  always_comb begin
    cmd.align = (in_data_i.cmd == CMD_ALIGN);
    if (32'(in_data_i.code_length) > MaxCodeLen) begin
      cmd.len = LenW'(MaxCodeLen);
    end else begin
      cmd.len = LenW'(in_data_i.code_length);
    end
    shifted  = 32'(in_data_i.code_value) << (32'(MaxCodeLen) - 32'(cmd.len));
    cmd.bits = shifted[MaxCodeLen-1:0];
  end

  // A write of zero bits has no effect, so it is dropped here.
  assign cmd_push_o = (push_i && !cmd_full_i) ? (cmd.align || (cmd.len != '0)) : 1'b0;
  assign cmd_data_o = cmd;

endmodule

[src/jbp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG bit packer back end
// Merges queued codes into the partial byte, emits bytes and stuffed zeros.
// ----------------------------------------------------------------------------
module jbp_back #(
  parameter int MaxCodeLen = 16,
  parameter int CmdW       = 1 + $clog2(MaxCodeLen + 1) + MaxCodeLen
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CmdW-1:0]    cmd_data_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  logic               out_full_i,
  output logic               out_push_o,
  output jbp_pkg::out_item_t out_data_o
);
  import jbp_pkg::*;

  localparam int LenW = $clog2(MaxCodeLen + 1);

  typedef struct packed {
    logic                  align;
    logic [LenW-1:0]       len;
    logic [MaxCodeLen-1:0] bits;
  } cmd_t;

  cmd_t                  cmd;
  logic                  busy_q, busy_d, align_q, align_d;
  logic                  stuff_q, stuff_d, stuff_last_q, stuff_last_d;
  logic [MaxCodeLen-1:0] code_q, code_d;
  logic [LenW-1:0]       rem_q, rem_d, rem_n;
  logic [7:0]            pend_q, pend_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [MaxCodeLen+7:0] code_ext;
  logic [7:0]            window, taken, new_byte, pad_byte;
  logic [3:0]            space, take, new_cnt;

  assign cmd = cmd_t'(cmd_data_i);

  always_comb begin
    code_ext = {code_q, 8'h00};
    window   = code_ext[MaxCodeLen+7:MaxCodeLen];
    space    = 4'(BYTE_BITS) - {1'b0, cnt_q};
    take     = (32'(rem_q) < 32'(space)) ? 4'(rem_q) : space;
    taken    = window & ~(8'hFF >> take);
    new_byte = pend_q | (taken >> cnt_q);
    new_cnt  = {1'b0, cnt_q} + take;
    rem_n    = rem_q - LenW'(take);
    pad_byte = pend_q | (8'hFF >> cnt_q);
  end

  always_comb begin
    busy_d       = busy_q;
    align_d      = align_q;
    stuff_d      = stuff_q;
    stuff_last_d = stuff_last_q;
    code_d       = code_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    cmd_pop_o    = 1'b0;
    out_push_o   = 1'b0;
    out_data_o   = '{out_byte: STUFF_BYTE, last_of_run: 1'b0};
    if (stuff_q) begin
      if (!out_full_i) begin
        out_push_o = 1'b1;
        out_data_o = '{out_byte: STUFF_BYTE, last_of_run: stuff_last_q};
        stuff_d    = 1'b0;
      end
    end else if (busy_q) begin
      if (align_q) begin
        if (cnt_q == '0) begin
          busy_d = 1'b0;
        end else if (!out_full_i) begin
          out_push_o   = 1'b1;
          out_data_o   = '{out_byte: pad_byte, last_of_run: pad_byte != STUFF_TRIGGER};
          stuff_d      = (pad_byte == STUFF_TRIGGER);
          stuff_last_d = 1'b1;
          pend_d       = '0;
          cnt_d        = '0;
          busy_d       = 1'b0;
        end
      end else if (new_cnt == 4'(BYTE_BITS)) begin
        if (!out_full_i) begin
          out_push_o   = 1'b1;
          out_data_o   = '{out_byte: new_byte,
                           last_of_run: (32'(rem_n) < BYTE_BITS) &&
                                        (new_byte != STUFF_TRIGGER)};
          stuff_d      = (new_byte == STUFF_TRIGGER);
          stuff_last_d = (32'(rem_n) < BYTE_BITS);
          pend_d       = '0;
          cnt_d        = '0;
          code_d       = code_q << take;
          rem_d        = rem_n;
          busy_d       = (rem_n != '0);
        end
      end else begin
        pend_d = new_byte;
        cnt_d  = new_cnt[2:0];
        code_d = code_q << take;
        rem_d  = rem_n;
        busy_d = (rem_n != '0);
      end
    end else if (!cmd_empty_i) begin
      cmd_pop_o = 1'b1;
      busy_d    = 1'b1;
      align_d   = cmd.align;
      code_d    = cmd.bits;
      rem_d     = cmd.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      align_q      <= 1'b0;
      stuff_q      <= 1'b0;
      stuff_last_q <= 1'b0;
      rem_q        <= '0;
      pend_q       <= '0;
      cnt_q        <= '0;
    end else begin
      busy_q       <= busy_d;
      align_q      <= align_d;
      stuff_q      <= stuff_d;
      stuff_last_q <= stuff_last_d;
      rem_q        <= rem_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

endmodule

[src/jpeg_bit_packer_with_stuffing_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG bit packer with byte stuffing
// Packs variable-length codes MSB first into entropy-coded segment bytes.
// ----------------------------------------------------------------------------
// Usage: a write transaction (cmd 0) appends the low code_length bits of
// code_value; an align transaction (cmd 1) pads the partial byte with ones
// and emits it. Every completed 0xFF byte is followed by a stuffed 0x00.
// The input side is a queue port: a transaction is taken when push is high
// and full is low. The output side is a queue port: the oldest byte shows
// while empty is low and is taken when pop is high.
// A taken transaction passes through the command queue, the back end load
// step and the output queue before its first byte is visible. The back end
// loads a transaction, then merges one byte-boundary segment of the code at a
// time (at most three for a 16-bit code) and emits any stuffed byte, and it
// takes no new transaction until it is through. Zero-length writes are dropped by
// the front end and cost the back end nothing.
// Reset clears the pending partial byte and empties both queues.
// When the receiver stalls, the output queue fills, the back end holds,
// and full rises once the command queue fills as well.
// ----------------------------------------------------------------------------
module jpeg_bit_packer_with_stuffing_core #(
  parameter int MaxCodeLen = jbp_pkg::MAX_CODE_LEN_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  jbp_pkg::in_item_t  in_data_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output jbp_pkg::out_item_t out_data_o
);
  import jbp_pkg::*;

  localparam int CmdW = 1 + $clog2(MaxCodeLen + 1) + MaxCodeLen;
  localparam int OutW = $bits(out_item_t);

  logic            cmd_push, cmd_pop, cmd_empty, out_push, out_full;
  logic [CmdW-1:0] cmd_wdata, cmd_rdata;
  out_item_t       out_wdata;
  logic [OutW-1:0] out_rdata;

  jbp_front #(.MaxCodeLen(MaxCodeLen), .CmdW(CmdW)) u_front (
    .push_i    (push),
    .in_data_i (in_data_i),
    .cmd_full_i(full),
    .cmd_push_o(cmd_push),
    .cmd_data_o(cmd_wdata)
  );

  jbp_fifo #(.Width(CmdW), .Depth(CMD_FIFO_DEPTH)) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_wdata),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_rdata),
    .empty_o(cmd_empty)
  );

  jbp_back #(.MaxCodeLen(MaxCodeLen), .CmdW(CmdW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_data_i (cmd_rdata),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (out_wdata)
  );

  jbp_fifo #(.Width(OutW), .Depth(OUT_FIFO_DEPTH)) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_wdata),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_rdata),
    .empty_o(empty)
  );

  assign out_data_o = out_item_t'(out_rdata);

endmodule
